>>> rtl/core/sbpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpq_pkg: shared types and codes for the sorted byte priority queue
// Operation and status codes, and the link and control structs of the cells.
// ----------------------------------------------------------------------------
package sbpq_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // operation codes carried on i_op
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // what one cell shows its neighbors
    typedef struct packed {
        logic              valid;  // cell holds a byte
        logic              lt;     // new byte sorts strictly before this one
        logic [BYTE_W-1:0] data;
    } t_cell_link;

    // broadcast control, same for every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

endpackage

>>> rtl/core/sbpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpq_cell: one slot of the sorted cell chain
// Holds one byte; on push takes the new byte or its left neighbor's byte,
// on pop takes its right neighbor's byte.
// ----------------------------------------------------------------------------
module sbpq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sbpq_pkg::t_cell_ctl   i_ctl,
    input  sbpq_pkg::t_cell_link  i_prev,   // toward head (smaller)
    input  sbpq_pkg::t_cell_link  i_next,   // toward tail (larger)
    output sbpq_pkg::t_cell_link  o_link
);

    logic                        r_valid;
    logic [sbpq_pkg::BYTE_W-1:0] r_data;
    logic                        n_valid;
    logic [sbpq_pkg::BYTE_W-1:0] n_data;
    logic                        lt;

    // strict compare: equal bytes stay behind, keeping arrival order
    assign lt = r_valid && (i_ctl.data < r_data);

    assign o_link.valid = r_valid;
    assign o_link.lt    = lt;
    assign o_link.data  = r_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.push) begin
            n_valid = r_valid | i_prev.valid;
            if (i_prev.lt) begin
                n_data = i_prev.data;       // shifted right by the insert
            end else if (lt || (!r_valid && i_prev.valid)) begin
                n_data = i_ctl.data;        // insert point
            end
        end else if (i_ctl.pop) begin
            n_valid = i_next.valid;
            n_data  = i_next.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

>>> rtl/core/sorted_byte_priority_queue.sv
`timescale 1ns / 1ps
// Latency: a command taken at an edge shows its result, with o_strobe, in the next cycle.
// Throughput: one command per cycle; busy never rises, as each cell takes its new byte at the same edge.
// Reset (i_rst_n low, synchronous): queue empty, no result pending.
// The receiver cannot stall: o_strobe marks every result for a single cycle.
// ----------------------------------------------------------------------------
// sorted_byte_priority_queue: byte priority queue built as a sorted cell chain
// Cell 0 always holds the smallest byte. A push is broadcast to all cells;
// each compares and either keeps its byte, takes the new byte, or takes its
// left neighbor's byte, so the chain opens a gap at the insert point. A pop
// shifts every cell one place toward the head.
// ----------------------------------------------------------------------------
module sorted_byte_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [sbpq_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                          o_strobe,
    output logic [sbpq_pkg::STATUS_W-1:0] o_status,
    output logic [sbpq_pkg::BYTE_W-1:0]   o_popped_byte,
    output logic [sbpq_pkg::FILL_W-1:0]   o_fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    sbpq_pkg::t_cell_link links [DEPTH];
    sbpq_pkg::t_cell_link prevs [DEPTH];
    sbpq_pkg::t_cell_link nexts [DEPTH];
    sbpq_pkg::t_cell_ctl  ctl;

    logic full;
    logic empty;
    logic do_push;
    logic do_pop;

    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic                            r_strobe;
    logic [sbpq_pkg::STATUS_W-1:0]   r_status;
    logic [sbpq_pkg::STATUS_W-1:0]   n_status;
    logic [sbpq_pkg::BYTE_W-1:0]     r_popped;
    logic [sbpq_pkg::BYTE_W-1:0]     n_popped;
    logic [CNT_W+sbpq_pkg::FILL_W-1:0] count_ext;

    // no command ever stalls
    assign busy = 1'b0;

    // chain is packed from cell 0, so its ends tell full and empty
    assign full  = links[DEPTH-1].valid;
    assign empty = !links[0].valid;

    assign do_push = start && (i_op == sbpq_pkg::OP_PUSH) && !full;
    assign do_pop  = start && (i_op == sbpq_pkg::OP_POP) && !empty;

    assign ctl.push = do_push;
    assign ctl.pop  = do_pop;
    assign ctl.data = i_data_byte;

    // neighbor wiring; head sees an always-full, never-smaller left side,
    // tail sees an empty right side
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                prevs[i].valid = 1'b1;
                prevs[i].lt    = 1'b0;
                prevs[i].data  = '0;
            end else begin
                prevs[i] = links[i-1];
            end
            if (i == DEPTH - 1) begin
                nexts[i].valid = 1'b0;
                nexts[i].lt    = 1'b0;
                nexts[i].data  = '0;
            end else begin
                nexts[i] = links[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sbpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_prev  (prevs[g]),
            .i_next  (nexts[g]),
            .o_link  (links[g])
        );
    end

    // result word and fill count
    always_comb begin
        n_count  = r_count;
        n_status = sbpq_pkg::ST_OK;
        n_popped = '0;
        if (i_op == sbpq_pkg::OP_PUSH) begin
            if (full) begin
                n_status = sbpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = sbpq_pkg::ST_EMPTY;
            end else begin
                n_count  = r_count - CNT_W'(1);
                n_popped = links[0].data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    // count reported modulo 32
    assign count_ext = {{sbpq_pkg::FILL_W{1'b0}}, r_count};

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_popped_byte = r_popped;
    assign o_fill_count  = count_ext[sbpq_pkg::FILL_W-1:0];

endmodule
